@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock and idle during reset.
`define PT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication.
`define PT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `PT_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define PT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  `PT_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

@@ rtl/pt_pkg.sv @@
`default_nettype none

package pt_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned PT_TABLE_INDEX_BITS = 12;
  localparam int unsigned PT_SAMPLE_BITS      = 16;

  // Table entries are unsigned magnitudes of round(32767*sin)
  localparam int unsigned PT_MAG_W   = 15;
  localparam int unsigned PT_FRAC_W  = 15;
  localparam logic [63:0] PT_HALF_PI_Q60 = 64'h1921FB54442D1847;
  localparam logic [63:0] PT_ONE_Q60     = 64'h1000000000000000;
  localparam logic [63:0] PT_ROM_SCALE   = 64'd32767;

  // Taylor series divisors: (2i)(2i+1) for sine, (2i-1)(2i) for cosine
  localparam logic [63:0] DIV_SIN [1:12] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};
  localparam logic [63:0] DIV_COS [1:12] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
    64'd132, 64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

  // Quadrant sign flags of one table lookup
  typedef struct packed {
    logic s_neg;
    logic c_neg;
  } pt_sign_t;

  // Stage enables handed from the top level to the datapath
  typedef struct packed {
    logic en_s2;
    logic en_s3;
  } pt_ctrl_t;

  // Q60 product, keep bits 123:60
  function automatic logic [63:0] pt_qmul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [63:0] pt_sin_q60(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = pt_qmul(x, x);
    term = x;
    sum  = x;
    for (int i = 1; i <= 12; i++) begin
      term = pt_qmul(term, x2) / DIV_SIN[i];
      sum  = (i % 2 == 1) ? sum - term : sum + term;
    end
    return sum;
  endfunction

  function automatic logic [63:0] pt_cos_q60(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = pt_qmul(x, x);
    term = PT_ONE_Q60;
    sum  = PT_ONE_Q60;
    for (int i = 1; i <= 12; i++) begin
      term = pt_qmul(term, x2) / DIV_COS[i];
      sum  = (i % 2 == 1) ? sum - term : sum + term;
    end
    return sum;
  endfunction

  // One quarter-wave entry, worked out at elaboration
  function automatic logic [PT_MAG_W-1:0] pt_quarter_entry(int unsigned m,
                                                           int unsigned tib);
    logic [63:0]  step;
    logic [63:0]  s;
    logic [127:0] prod;
    int unsigned  qtr;
    qtr  = 1 << (tib - 2);
    step = PT_HALF_PI_Q60 >> (tib - 2);
    if (2 * m <= qtr) begin
      s = pt_sin_q60(step * 64'(m));
    end else begin
      s = pt_cos_q60(step * 64'(qtr - m));
    end
    prod = {64'd0, s} * {64'd0, PT_ROM_SCALE} + (128'd1 << 59);
    return prod[60 +: PT_MAG_W];
  endfunction

endpackage

`default_nettype wire

@@ rtl/pt_sincos.sv @@
`default_nettype none

module pt_sincos
  import pt_pkg::*;
#(
  parameter int unsigned TABLE_INDEX_BITS = PT_TABLE_INDEX_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [15:0]         angle_i,
  output logic      [PT_MAG_W-1:0] sin_mag_o,
  output logic      [PT_MAG_W-1:0] cos_mag_o,
  output pt_sign_t                 sign_o
);

  localparam int unsigned QTR_LEN = 2 ** (TABLE_INDEX_BITS - 2);
  localparam int unsigned DEPTH   = QTR_LEN + 1;
  localparam int unsigned AW      = TABLE_INDEX_BITS - 1;

  typedef logic [PT_MAG_W-1:0] tab_t [DEPTH];

  function automatic tab_t build_table();
    tab_t t;
    for (int m = 0; m < DEPTH; m++) begin
      t[m] = pt_quarter_entry(m, TABLE_INDEX_BITS);
    end
    return t;
  endfunction

  localparam tab_t SIN_ROM = build_table();

  logic [TABLE_INDEX_BITS-1:0] idx;
  logic [1:0]                  quad;
  logic [1:0]                  cquad;
  logic [AW-2:0]               rem;
  logic [AW-1:0]               sin_addr;
  logic [AW-1:0]               cos_addr;
  logic [PT_MAG_W-1:0]         sin_mag_q;
  logic [PT_MAG_W-1:0]         cos_mag_q;
  pt_sign_t                    sign_d;
  pt_sign_t                    sign_q;

  // Split the angle into quadrant and offset; cosine is a quarter turn ahead
  assign idx   = angle_i[15 -: TABLE_INDEX_BITS];
  assign quad  = idx[TABLE_INDEX_BITS-1 -: 2];
  assign rem   = idx[TABLE_INDEX_BITS-3:0];
  assign cquad = quad + 2'd1;

  // Odd quadrants read the quarter wave backwards
  assign sin_addr = quad[0]  ? AW'(QTR_LEN) - {1'b0, rem} : {1'b0, rem};
  assign cos_addr = cquad[0] ? AW'(QTR_LEN) - {1'b0, rem} : {1'b0, rem};

  assign sign_d.s_neg = quad[1];
  assign sign_d.c_neg = cquad[1];

  // Registered table read, held on stall
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_mag_q <= SIN_ROM[sin_addr];
      cos_mag_q <= SIN_ROM[cos_addr];
      sign_q    <= sign_d;
    end
  end

  assign sin_mag_o = sin_mag_q;
  assign cos_mag_o = cos_mag_q;
  assign sign_o    = sign_q;

endmodule

`default_nettype wire

@@ rtl/pt_rotate.sv @@
`default_nettype none

module pt_rotate
  import pt_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = PT_SAMPLE_BITS
) (
  input  wire logic                          clk_i,
  input  wire pt_ctrl_t                      ctrl_i,
  input  wire logic signed [SAMPLE_BITS-1:0] alpha_i,
  input  wire logic signed [SAMPLE_BITS-1:0] beta_i,
  input  wire logic        [PT_MAG_W-1:0]    sin_mag_i,
  input  wire logic        [PT_MAG_W-1:0]    cos_mag_i,
  input  wire pt_sign_t                      sign_i,
  output logic signed      [SAMPLE_BITS:0]   d_axis_o,
  output logic signed      [SAMPLE_BITS:0]   q_axis_o
);

  localparam int unsigned PW = SAMPLE_BITS + PT_MAG_W + 1;
  localparam int unsigned SW = SAMPLE_BITS + PT_MAG_W + 2;
  localparam logic signed [SW-1:0] ROUND_HALF = SW'(2 ** (PT_FRAC_W - 1));

  logic signed [PT_MAG_W:0] sin_s;
  logic signed [PT_MAG_W:0] cos_s;
  logic signed [PW-1:0]     ac_q, bs_q, bc_q, as_q;
  pt_sign_t                 sign_q;
  logic signed [SW-1:0]     ac_x, bs_x, bc_x, as_x;
  logic signed [SW-1:0]     ac_t, bs_t, bc_t, as_t;
  logic signed [SW-1:0]     d_sum, q_sum;
  logic signed [SAMPLE_BITS:0] d_axis_q, q_axis_q;

  assign sin_s = $signed({1'b0, sin_mag_i});
  assign cos_s = $signed({1'b0, cos_mag_i});

  // Stage 2: four products on the table magnitudes
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_s2) begin
      ac_q   <= alpha_i * cos_s;
      bs_q   <= beta_i * sin_s;
      bc_q   <= beta_i * cos_s;
      as_q   <= alpha_i * sin_s;
      sign_q <= sign_i;
    end
  end

  // Apply quadrant signs, sum, round half up and drop the fraction
  assign ac_x = SW'(ac_q);
  assign bs_x = SW'(bs_q);
  assign bc_x = SW'(bc_q);
  assign as_x = SW'(as_q);

  assign ac_t = sign_q.c_neg ? -ac_x : ac_x;
  assign bc_t = sign_q.c_neg ? -bc_x : bc_x;
  assign bs_t = sign_q.s_neg ? -bs_x : bs_x;
  assign as_t = sign_q.s_neg ? -as_x : as_x;

  assign d_sum = ac_t + bs_t + ROUND_HALF;
  assign q_sum = bc_t - as_t + ROUND_HALF;

  // Stage 3: output register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_s3) begin
      d_axis_q <= d_sum[SAMPLE_BITS+PT_FRAC_W:PT_FRAC_W];
      q_axis_q <= q_sum[SAMPLE_BITS+PT_FRAC_W:PT_FRAC_W];
    end
  end

  assign d_axis_o = d_axis_q;
  assign q_axis_o = q_axis_q;

endmodule

`default_nettype wire

@@ rtl/park_transform.sv @@
// Park transform, three register stages: table read, multiply, sum and round.
// Throughput: one beat per cycle unless the output stalls; each stage refills as soon as
// its content moves on, so input stays ready while a result waits, until all three stages
// hold beats.
// Reset (rst_ni low, asynchronous) clears the stage valid bits; the sine table is constant.
`default_nettype none

module park_transform
  import pt_pkg::*;
#(
  parameter int unsigned TABLE_INDEX_BITS = PT_TABLE_INDEX_BITS,
  parameter int unsigned SAMPLE_BITS      = PT_SAMPLE_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] alpha_in_i,
  input  wire logic signed [SAMPLE_BITS-1:0] beta_in_i,
  input  wire logic        [15:0]            angle_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed      [SAMPLE_BITS:0]   d_axis_o,
  output logic signed      [SAMPLE_BITS:0]   q_axis_o
);

  logic     v1_q, v2_q, v3_q;
  logic     en_s1;
  pt_ctrl_t ctrl;
  logic signed [SAMPLE_BITS-1:0] alpha_q, beta_q;
  logic [PT_MAG_W-1:0] sin_mag, cos_mag;
  pt_sign_t            sign;

  // Each stage loads when empty or when its content moves on
  assign ctrl.en_s3 = !v3_q || out_ready_i;
  assign ctrl.en_s2 = !v2_q || ctrl.en_s3;
  assign en_s1      = !v1_q || ctrl.en_s2;
  assign in_ready_o = en_s1;

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en_s1)      v1_q <= in_valid_i;
      if (ctrl.en_s2) v2_q <= v1_q;
      if (ctrl.en_s3) v3_q <= v2_q;
    end
  end

  // Stage 1 samples beside the table read
  always_ff @(posedge clk_i) begin
    if (en_s1) begin
      alpha_q <= alpha_in_i;
      beta_q  <= beta_in_i;
    end
  end

  pt_sincos #(
    .TABLE_INDEX_BITS(TABLE_INDEX_BITS)
  ) u_sincos (
    .clk_i    (clk_i),
    .en_i     (en_s1),
    .angle_i  (angle_i),
    .sin_mag_o(sin_mag),
    .cos_mag_o(cos_mag),
    .sign_o   (sign)
  );

  pt_rotate #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_rotate (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .alpha_i  (alpha_q),
    .beta_i   (beta_q),
    .sin_mag_i(sin_mag),
    .cos_mag_i(cos_mag),
    .sign_i   (sign),
    .d_axis_o (d_axis_o),
    .q_axis_o (q_axis_o)
  );

  assign out_valid_o = v3_q;

endmodule

`default_nettype wire

@@ rtl/pt_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module pt_checker
  import pt_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = PT_SAMPLE_BITS
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic signed [SAMPLE_BITS-1:0] alpha_in_i,
  input wire logic signed [SAMPLE_BITS-1:0] beta_in_i,
  input wire logic        [15:0]            angle_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic signed [SAMPLE_BITS:0]   d_axis_o,
  input wire logic signed [SAMPLE_BITS:0]   q_axis_o
);

  logic       in_acc, out_acc;
  logic [2:0] occ_q, occ_d;
  logic       unused_payload;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign unused_payload = ^{alpha_in_i, beta_in_i, angle_i};

  // Track beats inside the pipeline
  assign occ_d = occ_q + 3'(in_acc) - 3'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 3'd0;
    end else begin
      occ_q <= occ_d;
    end
  end

  `PT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                 out_valid_o && $stable(d_axis_o) && $stable(q_axis_o), "result dropped on stall")
  `PT_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i,
                 "input held back without a blocked output")
  `PT_ASSERT_NXT(a_latency, clk_i, rst_ni,
                 in_acc && out_ready_i ##1 out_ready_i ##1 out_ready_i, out_valid_o,
                 "result late on a free output")
  `PT_ASSERT(a_occ_bound, clk_i, rst_ni, occ_q <= 3'd3 || unused_payload === 1'bx,
             "more beats in flight than stages")
  `PT_ASSERT_IMP(a_no_phantom, clk_i, rst_ni, out_valid_o, occ_q != 3'd0,
                 "result without an input beat")

endmodule

bind park_transform pt_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_pt_checker (.*);

`default_nettype wire

@@ sim/park_transform_tb.sv @@
`default_nettype none

module park_transform_tb
  import pt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SB      = PT_SAMPLE_BITS;
  localparam int unsigned TIB     = PT_TABLE_INDEX_BITS;
  localparam int unsigned QTR     = 1 << (TIB - 2);
  localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;
  localparam logic [63:0] PI_2Q60 = 64'h1921FB54442D1847;
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic signed [SB:0] d;
    logic signed [SB:0] q;
    logic [15:0]        ang;
  } dq_beat_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic signed [SB-1:0]   alpha_in_i;
  logic signed [SB-1:0]   beta_in_i;
  logic [15:0]            angle_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic signed [SB:0]     d_axis_o;
  logic signed [SB:0]     q_axis_o;

  // quarter-wave sine magnitudes, built once at start
  int       sine_rom [0:QTR];
  dq_beat_t expected_dq [$];
  int       mismatches    = 0;
  int       beats_in      = 0;
  int       results_out   = 0;
  bit       tx_gaps       = 1'b0;
  bit       rx_stalls_on  = 1'b0;
  int       rx_hold_req   = 0;

  park_transform dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .alpha_in_i  (alpha_in_i),
    .beta_in_i   (beta_in_i),
    .angle_i     (angle_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .d_axis_o    (d_axis_o),
    .q_axis_o    (q_axis_o)
  );

  always #6 clk_i = ~clk_i;

  // Q60 fixed-point product, keep bits 123:60
  function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Taylor series in Q60, sine when odd_series is set, cosine otherwise
  function automatic logic [63:0] series_q60(logic [63:0] x, bit odd_series);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] div;
    x2   = q60_mul(x, x);
    term = odd_series ? x : ONE_Q60;
    acc  = term;
    for (int i = 1; i <= 12; i++) begin
      div  = odd_series ? 64'((2 * i) * (2 * i + 1)) : 64'((2 * i - 1) * (2 * i));
      term = q60_mul(term, x2) / div;
      acc  = (i % 2 == 1) ? acc - term : acc + term;
    end
    return acc;
  endfunction

  // Fill the quarter wave: sine up to pi/4, cosine of the complement above
  task automatic build_sine_rom();
    logic [63:0]  stride;
    logic [63:0]  s;
    logic [127:0] scaled;
    stride = PI_2Q60 >> (TIB - 2);
    for (int m = 0; m <= QTR; m++) begin
      if (2 * m <= QTR) begin
        s = series_q60(stride * 64'(m), 1'b1);
      end else begin
        s = series_q60(stride * 64'(QTR - m), 1'b0);
      end
      scaled = {64'd0, s} * 128'd32767 + (128'd1 << 59);
      sine_rom[m] = int'(scaled[91:60]);
    end
  endtask

  // Full-turn sine from the quarter wave by quadrant folding
  function automatic longint rom_sine(int unsigned k);
    int unsigned quad;
    int unsigned r;
    longint      v;
    quad = (k >> (TIB - 2)) & 3;
    r    = k & (QTR - 1);
    v    = (quad & 1) ? longint'(sine_rom[QTR - r]) : longint'(sine_rom[r]);
    return (quad & 2) ? -v : v;
  endfunction

  // Rotate (alpha, beta) by the table angle, round half up, floor shift by 15
  function automatic dq_beat_t rotate_to_dq(logic signed [SB-1:0] a,
                                            logic signed [SB-1:0] b, logic [15:0] ang);
    dq_beat_t    r;
    longint      av;
    longint      bv;
    longint      sv;
    longint      cv;
    longint      acc;
    int unsigned k;
    int unsigned n;
    av  = longint'(a);
    bv  = longint'(b);
    n   = 1 << TIB;
    k   = 32'(ang) >> (16 - TIB);
    sv  = rom_sine(k);
    cv  = rom_sine((k + n / 4) & (n - 1));
    acc = av * cv + bv * sv + 16384;
    r.d = (SB+1)'(acc >>> 15);
    acc = bv * cv - av * sv + 16384;
    r.q = (SB+1)'(acc >>> 15);
    r.ang = ang;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Sample value: extremes and near-zero often, otherwise anything
  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return S_MIN;
      1: return S_MAX;
      2: return SB'($signed($urandom_range(0, 4)) - 2);
      default: return SB'($urandom);
    endcase
  endfunction

  // Angle: often close to a quadrant boundary, otherwise anything
  function automatic logic [15:0] rand_angle();
    if ($urandom_range(0, 3) == 0) begin
      return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 63) - 32);
    end
    return 16'($urandom);
  endfunction

  // Offer one beat and hold it until accepted; entered and left at a falling edge
  task automatic send_beat(logic signed [SB-1:0] a, logic signed [SB-1:0] b,
                           logic [15:0] ang);
    int gap;
    gap = tx_gaps ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    alpha_in_i = a;
    beta_in_i  = b;
    angle_i    = ang;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    in_valid_i = 1'b0;
  endtask

  // Receiver: long hold-off on request, random stalls when enabled
  initial begin
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left  = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_ready_i = 1'b0;
        gap_left--;
      end else begin
        out_ready_i = 1'b1;
        if (rx_stalls_on) gap_left = idle_len();
      end
    end
  end

  // Check each result beat against the oldest prediction, then log new input beats
  always @(posedge clk_i) begin
    dq_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_out++;
      if (expected_dq.size() == 0) begin
        report_mismatch("result beat with nothing pending", d_axis_o, 0);
      end else begin
        want = expected_dq.pop_front();
        if (d_axis_o !== want.d) report_mismatch($sformatf("d, angle %h", want.ang),
                                                 d_axis_o, want.d);
        if (q_axis_o !== want.q) report_mismatch($sformatf("q, angle %h", want.ang),
                                                 q_axis_o, want.q);
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_dq.push_back(rotate_to_dq(alpha_in_i, beta_in_i, angle_i));
      beats_in++;
    end
  end

  // Corners of the sample range at quadrant, octant and boundary angles; low angle bits ignored
  task automatic test_extremes();
    logic [15:0] corner_ang [6];
    corner_ang = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'hFFFF};
    tx_gaps      = 1'b0;
    rx_stalls_on = 1'b0;
    foreach (corner_ang[i]) begin
      send_beat(S_MIN, S_MIN, corner_ang[i]);
      send_beat(S_MAX, S_MAX, corner_ang[i]);
    end
    send_beat(S_MIN, S_MAX, 16'h6000);
    send_beat(S_MAX, S_MIN, 16'hE000);
    send_beat(S_MIN, '0, 16'h3FFF);
    send_beat('0, S_MIN, 16'h4010);
    send_beat('0, '0, 16'h1234);
    send_beat(SB'(1), -SB'(1), 16'h000F);
    send_beat(-SB'(1), SB'(1), 16'h0010);
    send_beat(S_MAX, S_MIN, 16'hA00F);
    end_burst();
  endtask

  // Random beats with idling on both sides
  task automatic test_random_idle(int count);
    tx_gaps      = 1'b1;
    rx_stalls_on = 1'b1;
    repeat (count) send_beat(rand_sample(), rand_sample(), rand_angle());
    end_burst();
  endtask

  // Back-to-back beats with the receiver always ready
  task automatic test_streaming(int count);
    tx_gaps      = 1'b0;
    rx_stalls_on = 1'b0;
    repeat (count) send_beat(rand_sample(), rand_sample(), rand_angle());
    end_burst();
  endtask

  // Hold the output off for a long stretch while the sender keeps offering
  task automatic test_output_holdoff(int count);
    tx_gaps      = 1'b0;
    rx_stalls_on = 1'b0;
    rx_hold_req  = HOLD_OFF_CYCLES;
    repeat (count) send_beat(rand_sample(), rand_sample(), rand_angle());
    end_burst();
  endtask

  // Steady input against a stalling receiver
  task automatic test_output_stalls(int count);
    tx_gaps      = 1'b0;
    rx_stalls_on = 1'b1;
    repeat (count) send_beat(rand_sample(), rand_sample(), rand_angle());
    end_burst();
    rx_stalls_on = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_ready_i = 1'b0;
    alpha_in_i  = '0;
    beta_in_i   = '0;
    angle_i     = '0;
    build_sine_rom();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_random_idle(600);
    test_streaming(150);
    test_output_holdoff(100);
    test_output_stalls(80);

    // drain, then allow the pipeline depth and a margin
    while (expected_dq.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (expected_dq.size() != 0) report_mismatch("results never delivered",
                                                 0, expected_dq.size());

    $display("Covered %0d input beats and %0d result beats: range corners, quadrant", beats_in,
             results_out);
    $display("edges, random idling on both sides and a %0d-cycle output hold-off.",
             HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Timed out with %0d results still pending", expected_dq.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

@@ park_transform.f @@
+incdir+rtl
rtl/pt_pkg.sv
rtl/pt_sincos.sv
rtl/pt_rotate.sv
rtl/park_transform.sv
rtl/pt_checker.sv
sim/park_transform_tb.sv
